FILE: rtl/core/utf8ps_pkg.sv
// types, constants and substitution tables shared by the punctuation substituter
package utf8ps_pkg;

   localparam int WIN_DEPTH = 5;
   localparam int NUM_PAT   = 12;
   localparam int REP_MAX   = 3;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] fill_type;
   typedef logic [3:0] pat_idx_type;
   typedef logic [1:0] rep_cnt_type;

   // one decision: up to three bytes to emit, their count and the end-of-text mark
   typedef struct packed {
      logic [REP_MAX-1:0][7:0] data;
      rep_cnt_type             count;
      logic                    last;
   } cmd_type;

   localparam fill_type PAT_LEN [NUM_PAT] = '{
      3'd3, 3'd3, 3'd2, 3'd3, 3'd5, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2
   };

   localparam byte_type PAT_BYTES [NUM_PAT][WIN_DEPTH] = '{
      '{8'hE2, 8'h80, 8'h99, 8'h00, 8'h00},
      '{8'hE2, 8'h80, 8'h98, 8'h00, 8'h00},
      '{8'hCA, 8'hBC, 8'h00, 8'h00, 8'h00},
      '{8'hE2, 8'h80, 8'hA6, 8'h00, 8'h00},
      '{8'h20, 8'hE2, 8'h80, 8'h94, 8'h20},
      '{8'h20, 8'hE2, 8'h80, 8'h93, 8'h20},
      '{8'hE2, 8'h80, 8'h94, 8'h00, 8'h00},
      '{8'hE2, 8'h80, 8'h93, 8'h00, 8'h00},
      '{8'hC2, 8'hA0, 8'h00, 8'h00, 8'h00},
      '{8'hE2, 8'h80, 8'hAF, 8'h00, 8'h00},
      '{8'hC3, 8'h80, 8'h00, 8'h00, 8'h00},
      '{8'hC5, 8'h92, 8'h00, 8'h00, 8'h00}
   };

   localparam rep_cnt_type REP_LEN [NUM_PAT] = '{
      2'd1, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2
   };

   localparam byte_type REP_BYTES [NUM_PAT][REP_MAX] = '{
      '{8'h27, 8'h00, 8'h00},
      '{8'h27, 8'h00, 8'h00},
      '{8'h27, 8'h00, 8'h00},
      '{8'h2E, 8'h2E, 8'h2E},
      '{8'h2C, 8'h20, 8'h00},
      '{8'h2C, 8'h20, 8'h00},
      '{8'h2C, 8'h20, 8'h00},
      '{8'h2C, 8'h20, 8'h00},
      '{8'h20, 8'h00, 8'h00},
      '{8'h20, 8'h00, 8'h00},
      '{8'h41, 8'h00, 8'h00},
      '{8'h4F, 8'h65, 8'h00}
   };

endpackage

FILE: rtl/core/utf8ps_if.sv
// valid/ready stream interfaces for the request and response channels
interface utf8ps_req_if;
   logic                valid;
   logic                ready;
   utf8ps_pkg::byte_type in_byte;
   logic                in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utf8ps_rsp_if;
   logic                valid;
   logic                ready;
   utf8ps_pkg::byte_type out_byte;
   logic                out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/core/utf8ps_front.sv
// front end: lookahead window, pattern match and decision issue
module utf8ps_front (
   input  logic                clock,
   input  logic                reset,
   utf8ps_req_if.sink          req,
   output logic                push_valid,
   output utf8ps_pkg::cmd_type push_cmd,
   input  logic                push_ready
);

   utf8ps_pkg::byte_type window_ff [utf8ps_pkg::WIN_DEPTH];
   utf8ps_pkg::byte_type window_in [utf8ps_pkg::WIN_DEPTH];
   utf8ps_pkg::fill_type fill_ff, fill_in;
   logic                 flush_ff, flush_in;

   logic [utf8ps_pkg::NUM_PAT-1:0] hit;
   logic                           found;
   utf8ps_pkg::pat_idx_type        sel;
   utf8ps_pkg::fill_type           used;
   utf8ps_pkg::fill_type           base_fill;
   logic                           do_decide;
   logic                           accept;
   logic [3:0]                     src;

   // pattern compare against the valid part of the window
   always_comb begin
      for (int k = 0; k < utf8ps_pkg::NUM_PAT; k++) begin
         hit[k] = (utf8ps_pkg::PAT_LEN[k] <= fill_ff);
         for (int j = 0; j < utf8ps_pkg::WIN_DEPTH; j++) begin
            if (utf8ps_pkg::fill_type'(j) < utf8ps_pkg::PAT_LEN[k] &&
                window_ff[j] != utf8ps_pkg::PAT_BYTES[k][j]) begin
               hit[k] = 1'b0;
            end
         end
      end
      found = |hit;
      sel   = '0;
      // lowest table entry wins
      for (int k = utf8ps_pkg::NUM_PAT - 1; k >= 0; k--) begin
         if (hit[k]) begin
            sel = utf8ps_pkg::pat_idx_type'(k);
         end
      end
   end

   always_comb begin
      push_cmd = '0;
      if (found) begin
         used           = utf8ps_pkg::PAT_LEN[sel];
         push_cmd.count = utf8ps_pkg::REP_LEN[sel];
         for (int j = 0; j < utf8ps_pkg::REP_MAX; j++) begin
            push_cmd.data[j] = utf8ps_pkg::REP_BYTES[sel][j];
         end
      end else begin
         used             = 3'd1;
         push_cmd.count   = 2'd1;
         push_cmd.data[0] = window_ff[0];
      end
      push_cmd.last = flush_ff && (used == fill_ff);
   end

   // decide when the window is full or while flushing the tail of a text
   assign push_valid = flush_ff || (fill_ff == utf8ps_pkg::fill_type'(utf8ps_pkg::WIN_DEPTH));
   assign do_decide  = push_valid && push_ready;
   assign req.ready  = !flush_ff &&
                       ((fill_ff != utf8ps_pkg::fill_type'(utf8ps_pkg::WIN_DEPTH)) || push_ready);
   assign accept     = req.valid && req.ready;
   assign base_fill  = do_decide ? fill_ff - used : fill_ff;

   always_comb begin
      src = '0;
      for (int i = 0; i < utf8ps_pkg::WIN_DEPTH; i++) begin
         window_in[i] = window_ff[i];
         if (do_decide) begin
            src = 4'(i) + {1'b0, used};
            if (src < 4'(utf8ps_pkg::WIN_DEPTH)) begin
               window_in[i] = window_ff[src[2:0]];
            end
         end
         if (accept && utf8ps_pkg::fill_type'(i) == base_fill) begin
            window_in[i] = req.in_byte;
         end
      end
      fill_in  = base_fill + utf8ps_pkg::fill_type'(accept);
      flush_in = flush_ff;
      if (accept && req.in_last) begin
         flush_in = 1'b1;
      end else if (do_decide && base_fill == '0) begin
         flush_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

FILE: rtl/core/utf8ps_queue.sv
// small fifo of decisions between the front and back ends
module utf8ps_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  utf8ps_pkg::cmd_type push_cmd,
   output logic                push_ready,
   output logic                head_valid,
   output utf8ps_pkg::cmd_type head_cmd,
   input  logic                pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   utf8ps_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/utf8ps_back.sv
// back end: expands decisions into output bytes through a registered output stage
module utf8ps_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  utf8ps_pkg::cmd_type head_cmd,
   output logic                pop,
   utf8ps_rsp_if.source        rsp
);

   utf8ps_pkg::rep_cnt_type idx_ff, idx_in;
   logic                    out_valid_ff, out_valid_in;
   utf8ps_pkg::byte_type    out_byte_ff, out_byte_in;
   logic                    out_last_ff, out_last_in;
   logic                    load;
   logic                    tail;

   assign load = head_valid && (!out_valid_ff || rsp.ready);
   assign tail = (idx_ff == head_cmd.count - 2'd1);
   assign pop  = load && tail;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = head_cmd.data[idx_ff];
         // only the final byte of the final decision closes the text
         out_last_in  = head_cmd.last && tail;
         idx_in       = tail ? '0 : idx_ff + 2'd1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.out_last = out_last_ff;

endmodule

FILE: rtl/core/utf8_punctuation_substituter.sv
// top level of the utf-8 punctuation substituter
// Takes a utf-8 text one byte per item on req (in_byte, in_last marks the final
// byte of a text) and returns the rewritten text on rsp (out_byte, out_last).
// Typographic quotes, dashes, ellipsis, no-break spaces and a few letters are
// replaced by plain ascii; any other byte passes through unchanged.
// The front end holds a five-byte lookahead window and makes one decision per
// cycle while the queue has room; decisions go through a small queue to the
// back end, which emits one byte per cycle (while rsp.ready is high) from a
// registered output stage. Throughput: one input item per cycle while a text
// streams and the queue has room. After the last byte of a text the front end
// flushes the window, one decision a cycle while the queue has room, and
// req.ready stays low until the window is empty. A decision passes through
// the queue and the output register; it waits for a full window or text end.
// Reset empties the window, the queue and the output stage.
// When rsp.ready is low the output byte holds, the queue fills and then
// req.ready drops; nothing is lost.
module utf8_punctuation_substituter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   utf8ps_req_if.sink   req,
   utf8ps_rsp_if.source rsp
);

   logic                push_valid;
   logic                push_ready;
   utf8ps_pkg::cmd_type push_cmd;
   logic                head_valid;
   utf8ps_pkg::cmd_type head_cmd;
   logic                pop;

   utf8ps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   utf8ps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   utf8ps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp)
   );

   // a decision stalled by a full queue must not change
   a_decision_holds: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> push_valid && $stable(push_cmd))
      else $error("decision changed while the queue was full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_cmd.count != '0)
      else $error("decision with no bytes to emit");

endmodule
